// ===== rtl/core/rcrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Read coils response parser package
// Shared widths, status codes and the command word passed from the front end
// to the back end.
// ----------------------------------------------------------------------------
package rcrp_pkg;

    localparam int COIL_CNT_W     = 11;
    localparam int FUNC_W         = 7;
    localparam int BYTE_W         = 8;
    localparam int STATUS_W       = 2;
    localparam int DEF_MAX_COILS  = 2000;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXCEPTION  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNEXPECTED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_COUNT  = 2'd3;

    localparam logic [BYTE_W-1:0] EXC_FLAG = 8'h80;

    localparam logic [0:0] REG_COIL_COUNT = 1'b0;
    localparam logic [0:0] REG_FUNC_CODE  = 1'b1;

    typedef struct packed {
        logic                data_valid;
        logic [BYTE_W-1:0]   data_byte;
        logic [BYTE_W-1:0]   data_index;
        logic                done;
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   exc_value;
    } t_cmd;

endpackage

// ===== rtl/core/rcrp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Read coils response parser front end
// Accepts PDU beats, tracks the frame position and status, and classifies
// each beat into a command for the back end.
// ----------------------------------------------------------------------------
module rcrp_front
    import rcrp_pkg::*;
#(
    parameter int MAX_COILS = DEF_MAX_COILS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [BYTE_W-1:0]     i_pdu_byte,
    input  logic                  i_pdu_last,
    input  logic [COIL_CNT_W-1:0] i_coil_count,
    input  logic [FUNC_W-1:0]     i_function_code,
    input  logic                  i_full,
    output logic                  o_push,
    output t_cmd                  o_cmd
);

    localparam logic [COIL_CNT_W-1:0] MaxCoils = COIL_CNT_W'(MAX_COILS);

    logic [BYTE_W-1:0]   r_pos;
    logic [STATUS_W-1:0] r_err;
    logic [BYTE_W-1:0]   r_exc;
    logic [BYTE_W-1:0]   r_decl;

    logic [BYTE_W-1:0]   n_pos;
    logic [STATUS_W-1:0] n_err;
    logic [BYTE_W-1:0]   n_exc;
    logic [BYTE_W-1:0]   n_decl;

    logic                count_ok;
    logic [BYTE_W:0]     expected;
    logic [COIL_CNT_W:0] cc_round;
    logic [BYTE_W-1:0]   di;
    logic [BYTE_W:0]     di_next;

    assign o_push   = i_valid && !i_full;
    assign count_ok = (i_coil_count != '0) && (i_coil_count <= MaxCoils);
    assign cc_round = {1'b0, i_coil_count} + (COIL_CNT_W+1)'(7);
    assign expected = cc_round[COIL_CNT_W:3];
    assign di       = r_pos - BYTE_W'(2);
    assign di_next  = {1'b0, di} + (BYTE_W+1)'(1);

    always_comb begin
        n_err = r_err;
        n_exc = r_exc;
        n_decl = r_decl;
        o_cmd = '0;
        if (r_pos == '0) begin
            if (i_pdu_byte == (EXC_FLAG | {1'b0, i_function_code})) begin
                n_err = ST_EXCEPTION;
            end else if (i_pdu_byte == {1'b0, i_function_code}) begin
                if (i_pdu_last) begin
                    n_err = ST_BAD_COUNT;
                end
            end else begin
                n_err = ST_UNEXPECTED;
            end
        end else if (r_pos == BYTE_W'(1)) begin
            if (r_err == ST_EXCEPTION) begin
                n_exc = i_pdu_byte;
            end else if (r_err == ST_OK) begin
                n_decl = i_pdu_byte;
                if (!count_ok || ({1'b0, i_pdu_byte} != expected) || i_pdu_last) begin
                    n_err = ST_BAD_COUNT;
                end
            end
        end else if (r_err == ST_OK) begin
            if (di >= r_decl) begin
                n_err = ST_BAD_COUNT;
            end else begin
                o_cmd.data_valid = 1'b1;
                o_cmd.data_byte  = i_pdu_byte;
                o_cmd.data_index = di;
                if (i_pdu_last && (di_next != {1'b0, r_decl})) begin
                    n_err = ST_BAD_COUNT;
                end
            end
        end
        n_pos = (r_pos != '1) ? r_pos + BYTE_W'(1) : r_pos;
        if (i_pdu_last) begin
            o_cmd.done      = 1'b1;
            o_cmd.status    = n_err;
            o_cmd.exc_value = (n_err == ST_EXCEPTION) ? n_exc : '0;
            n_pos  = '0;
            n_err  = ST_OK;
            n_exc  = '0;
            n_decl = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_err  <= ST_OK;
            r_exc  <= '0;
            r_decl <= '0;
        end else if (o_push) begin
            r_pos  <= n_pos;
            r_err  <= n_err;
            r_exc  <= n_exc;
            r_decl <= n_decl;
        end
    end

endmodule

// ===== rtl/core/rcrp_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Read coils response parser command queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module rcrp_fifo
    import rcrp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_nonempty,
    output t_cmd o_cmd
);

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QAW:0]   r_cnt;

    assign o_full     = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_cmd      = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (QAW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (QAW+1)'(1);
            end
        end
    end

endmodule

// ===== rtl/core/rcrp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Read coils response parser back end
// Masks coil bits past the requested coil count and holds the result beat in
// an output register.
// ----------------------------------------------------------------------------
module rcrp_back
    import rcrp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    input  t_cmd                  i_cmd,
    input  logic [COIL_CNT_W-1:0] i_coil_count,
    input  logic                  i_stall,
    output logic                  o_pop,
    output logic                  o_valid,
    output logic [BYTE_W-1:0]     o_coil_bits,
    output logic                  o_coil_valid,
    output logic [BYTE_W-1:0]     o_byte_index,
    output logic                  o_done_res,
    output logic [STATUS_W-1:0]   o_status,
    output logic [BYTE_W-1:0]     o_exception_value
);

    logic                  r_valid;
    logic [BYTE_W-1:0]     r_bits;
    logic                  r_cv;
    logic [BYTE_W-1:0]     r_idx;
    logic                  r_done;
    logic [STATUS_W-1:0]   r_status;
    logic [BYTE_W-1:0]     r_exv;

    logic [COIL_CNT_W-1:0] first;
    logic [COIL_CNT_W-1:0] rem;
    logic [BYTE_W-1:0]     mask;
    logic [BYTE_W-1:0]     n_bits;

    assign o_pop = i_cmd_valid && (!r_valid || !i_stall);
    assign first = {i_cmd.data_index, 3'b000};
    assign rem   = i_coil_count - first;

    always_comb begin
        if (first >= i_coil_count) begin
            mask = '0;
        end else if (rem >= COIL_CNT_W'(BYTE_W)) begin
            mask = '1;
        end else begin
            mask = BYTE_W'((BYTE_W'(1) << rem[2:0]) - BYTE_W'(1));
        end
        n_bits = i_cmd.data_valid ? (i_cmd.data_byte & mask) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bits   <= n_bits;
            r_cv     <= i_cmd.data_valid;
            r_idx    <= i_cmd.data_index;
            r_done   <= i_cmd.done;
            r_status <= i_cmd.status;
            r_exv    <= i_cmd.exc_value;
        end
    end

    assign o_valid           = r_valid;
    assign o_coil_bits       = r_bits;
    assign o_coil_valid      = r_cv;
    assign o_byte_index      = r_idx;
    assign o_done_res        = r_done;
    assign o_status          = r_status;
    assign o_exception_value = r_exv;

endmodule

// ===== rtl/core/read_coils_response_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Read coils response parser
// Checks a read coils response PDU beat by beat and emits masked coil bytes
// with a final status on the last beat.
//
//   Channel   Direction  Handshake          Payload
//   pdu       in         i_valid / o_stall  i_pdu_byte, i_pdu_last
//   result    out        o_valid / i_stall  o_coil_bits ... o_exception_value
//   config    in         APB                coil_count, function_code
//
// One beat is accepted per cycle while the queue is not full; each input beat gives one result beat.
// The front end classifies a beat into the queue and the back end masks it into
// the output register.
// The front end stalls only when the four-entry queue is full.
// Reset clears the frame state, empties the queue and clears the output valid flag.
// ----------------------------------------------------------------------------
module read_coils_response_parser
    import rcrp_pkg::*;
#(
    parameter int MAX_COILS = DEF_MAX_COILS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [BYTE_W-1:0]   i_pdu_byte,
    input  logic                i_pdu_last,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [BYTE_W-1:0]   o_coil_bits,
    output logic                o_coil_valid,
    output logic [BYTE_W-1:0]   o_byte_index,
    output logic                o_done_res,
    output logic [STATUS_W-1:0] o_status,
    output logic [BYTE_W-1:0]   o_exception_value,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [COIL_CNT_W-1:0] r_coil_count;
    logic [FUNC_W-1:0]     r_function_code;
    logic                  cfg_wr;

    logic push;
    logic full;
    logic nonempty;
    logic pop;
    t_cmd front_cmd;
    t_cmd queue_cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coil_count    <= COIL_CNT_W'(1);
            r_function_code <= FUNC_W'(1);
        end else if (cfg_wr) begin
            if (paddr[2] == REG_COIL_COUNT) begin
                r_coil_count <= pwdata[COIL_CNT_W-1:0];
            end else begin
                r_function_code <= pwdata[FUNC_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_FUNC_CODE) begin
            prdata = {{(32-FUNC_W){1'b0}}, r_function_code};
        end else begin
            prdata = {{(32-COIL_CNT_W){1'b0}}, r_coil_count};
        end
    end

    assign o_stall = full;

    rcrp_front #(
        .MAX_COILS(MAX_COILS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_pdu_byte     (i_pdu_byte),
        .i_pdu_last     (i_pdu_last),
        .i_coil_count   (r_coil_count),
        .i_function_code(r_function_code),
        .i_full         (full),
        .o_push         (push),
        .o_cmd          (front_cmd)
    );

    rcrp_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_cmd     (front_cmd),
        .i_pop     (pop),
        .o_full    (full),
        .o_nonempty(nonempty),
        .o_cmd     (queue_cmd)
    );

    rcrp_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (nonempty),
        .i_cmd            (queue_cmd),
        .i_coil_count     (r_coil_count),
        .i_stall          (i_stall),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .o_coil_bits      (o_coil_bits),
        .o_coil_valid     (o_coil_valid),
        .o_byte_index     (o_byte_index),
        .o_done_res       (o_done_res),
        .o_status         (o_status),
        .o_exception_value(o_exception_value)
    );

    a_no_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_coil_valid |-> o_coil_bits == '0 && o_byte_index == '0)
        else $error("coil fields nonzero without a data byte");

    a_exv_only_exc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_EXCEPTION |-> o_exception_value == '0)
        else $error("exception value without exception status");

    a_status_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_done_res |-> o_status == ST_OK)
        else $error("status reported before the last beat");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output or stall active after reset");

endmodule

// ===== verif/read_coils_response_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Read coils response parser testbench
// Feeds response PDUs beat by beat under several coil counts and function
// codes, predicts every result beat from its own model of the parser, and
// checks the results in order while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module read_coils_response_parser_tb
    import rcrp_pkg::*;
();

    localparam int COIL_LIMIT  = DEF_MAX_COILS;
    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD   = 80;
    localparam int HOLD_AT_A   = 400;
    localparam int HOLD_AT_B   = 1300;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_pdu_beat;

    typedef struct packed {
        logic [BYTE_W-1:0]   coil_bits;
        logic                coil_valid;
        logic [BYTE_W-1:0]   byte_index;
        logic                done;
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   exc_value;
    } t_coil_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [BYTE_W-1:0]   i_pdu_byte;
    logic                i_pdu_last;
    logic                o_valid;
    logic                i_stall;
    logic [BYTE_W-1:0]   o_coil_bits;
    logic                o_coil_valid;
    logic [BYTE_W-1:0]   o_byte_index;
    logic                o_done_res;
    logic [STATUS_W-1:0] o_status;
    logic [BYTE_W-1:0]   o_exception_value;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    t_pdu_beat    pdu_beats[$];
    t_coil_result parsed_beats[$];

    logic [COIL_CNT_W-1:0] cfg_coils;
    logic [FUNC_W-1:0]     cfg_func;
    logic [BYTE_W-1:0]     frame_pos;
    logic [STATUS_W-1:0]   frame_status;
    logic [BYTE_W-1:0]     frame_exc;
    logic [BYTE_W-1:0]     decl_count;

    int  mismatches;
    int  results_seen;
    int  beats_queued;
    int  cycles;
    int  snd_gap;
    int  stall_left;
    bit  snd_burst;
    bit  rcv_burst;
    bit  pdu_taken;
    bit  res_taken;

    read_coils_response_parser dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_pdu_byte        (i_pdu_byte),
        .i_pdu_last        (i_pdu_last),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_coil_bits       (o_coil_bits),
        .o_coil_valid      (o_coil_valid),
        .o_byte_index      (o_byte_index),
        .o_done_res        (o_done_res),
        .o_status          (o_status),
        .o_exception_value (o_exception_value),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_coil_result parse_pdu_byte(input logic [BYTE_W-1:0] b,
                                                    input logic last);
        t_coil_result r;
        int coils;
        int di;
        int first;
        logic [BYTE_W-1:0] mask;
        r = '0;
        coils = int'(cfg_coils);
        if (frame_pos == 0) begin
            if (b == {1'b1, cfg_func}) begin
                frame_status = ST_EXCEPTION;
            end else if (b == {1'b0, cfg_func}) begin
                if (last) frame_status = ST_BAD_COUNT;
            end else begin
                frame_status = ST_UNEXPECTED;
            end
        end else if (frame_pos == 1) begin
            if (frame_status == ST_EXCEPTION) begin
                frame_exc = b;
            end else if (frame_status == ST_OK) begin
                decl_count = b;
                if (coils == 0 || coils > COIL_LIMIT || int'(b) != (coils + 7) / 8 || last)
                    frame_status = ST_BAD_COUNT;
            end
        end else if (frame_status == ST_OK) begin
            di = int'(frame_pos) - 2;
            if (di >= int'(decl_count)) begin
                frame_status = ST_BAD_COUNT;
            end else begin
                first = di * 8;
                if (first >= coils) mask = '0;
                else if (coils - first >= 8) mask = 8'hFF;
                else mask = 8'((1 << (coils - first)) - 1);
                r.coil_bits  = b & mask;
                r.coil_valid = 1'b1;
                r.byte_index = di[BYTE_W-1:0];
                if (last && di + 1 != int'(decl_count)) frame_status = ST_BAD_COUNT;
            end
        end
        if (frame_pos != 8'hFF) frame_pos = frame_pos + 1'b1;
        if (last) begin
            r.done      = 1'b1;
            r.status    = frame_status;
            r.exc_value = (frame_status == ST_EXCEPTION) ? frame_exc : '0;
            frame_pos    = '0;
            frame_status = ST_OK;
            frame_exc    = '0;
            decl_count   = '0;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Accepted beats on both channels are seen here at the rising edge.
    always @(posedge i_clk) begin
        t_coil_result want;
        pdu_taken = 1'b0;
        res_taken = 1'b0;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                pdu_taken = 1'b1;
                parsed_beats.push_back(parse_pdu_byte(i_pdu_byte, i_pdu_last));
            end
            if (o_valid && !i_stall) begin
                res_taken = 1'b1;
                results_seen++;
                if (parsed_beats.size() == 0) begin
                    $error("result beat with no beat outstanding");
                    mismatches++;
                end else begin
                    want = parsed_beats.pop_front();
                    check_field("coil_bits", want.coil_bits, o_coil_bits);
                    check_field("coil_valid", want.coil_valid, o_coil_valid);
                    check_field("byte_index", want.byte_index, o_byte_index);
                    check_field("done_res", want.done, o_done_res);
                    check_field("status", want.status, o_status);
                    check_field("exception_value", want.exc_value, o_exception_value);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        t_pdu_beat beat;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || pdu_taken) begin
            if (snd_gap > 0) begin
                snd_gap = snd_gap - 1;
                i_valid <= 1'b0;
            end else if (pdu_beats.size() != 0) begin
                beat = pdu_beats.pop_front();
                i_pdu_byte <= beat.data;
                i_pdu_last <= beat.last;
                i_valid    <= 1'b1;
                if ($urandom_range(0, 63) == 0) snd_burst = !snd_burst;
                snd_gap = snd_burst ? 0 : $urandom_range(0, 7);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // The long holds back the block up until it stalls its input.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (res_taken) begin
                if (results_seen == HOLD_AT_A || results_seen == HOLD_AT_B) begin
                    stall_left = LONG_HOLD;
                end else begin
                    if ($urandom_range(0, 63) == 0) rcv_burst = !rcv_burst;
                    stall_left = rcv_burst ? 0 : $urandom_range(0, 7);
                end
            end
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic push_beat(input logic [BYTE_W-1:0] data, input logic last);
        pdu_beats.push_back('{data: data, last: last});
        beats_queued++;
    endtask

    task automatic push_raw_frame(input logic [BYTE_W-1:0] head, input int n_more);
        push_beat(head, n_more == 0);
        for (int i = 0; i < n_more; i++) push_beat(BYTE_W'($urandom), i == n_more - 1);
    endtask

    task automatic push_read_frame(input logic [BYTE_W-1:0] count, input int n_data);
        push_beat({1'b0, cfg_func}, 1'b0);
        push_raw_frame(count, n_data);
    endtask

    task automatic push_random_frame();
        int pick;
        int need;
        int n;
        logic [BYTE_W-1:0] head;
        need = (int'(cfg_coils) + 7) / 8;
        if (cfg_coils == 0 || cfg_coils > COIL_LIMIT) need = $urandom_range(0, 3);
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            push_read_frame(BYTE_W'(need), need);
        end else if (pick < 78) begin
            push_raw_frame({1'b1, cfg_func}, $urandom_range(0, 3));
        end else if (pick < 86) begin
            n = need + $urandom_range(0, 4) - 2;
            if (n < 0) n = 0;
            push_read_frame(BYTE_W'(need), n);
        end else if (pick < 91) begin
            push_read_frame(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 4));
        end else if (pick < 96) begin
            do head = BYTE_W'($urandom); while (head[FUNC_W-1:0] == cfg_func);
            push_raw_frame(head, $urandom_range(0, 4));
        end else begin
            push_raw_frame({1'b0, cfg_func}, 0);
        end
    endtask

    task automatic push_random_phase(input int target);
        int start;
        start = beats_queued;
        while (beats_queued - start < target) push_random_frame();
    endtask

    task automatic wait_drained();
        while (pdu_beats.size() != 0 || i_valid || parsed_beats.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic apb_access(input logic [0:0] index, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field(index == REG_COIL_COUNT ? "coil_count readback" : "function_code readback",
                    value, prdata);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input int coils, input int func);
        apb_access(REG_COIL_COUNT, coils & 32'h7FF);
        apb_access(REG_FUNC_CODE, func & 32'h7F);
        cfg_coils = coils[COIL_CNT_W-1:0];
        cfg_func  = func[FUNC_W-1:0];
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_pdu_byte   = '0;
        i_pdu_last   = 1'b0;
        i_stall      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        cfg_coils    = 11'd1;
        cfg_func     = 7'd1;
        frame_pos    = '0;
        frame_status = ST_OK;
        frame_exc    = '0;
        decl_count   = '0;
        mismatches   = 0;
        results_seen = 0;
        beats_queued = 0;
        cycles       = 0;
        snd_gap      = 0;
        stall_left   = 0;
        snd_burst    = 1'b0;
        rcv_burst    = 1'b0;

        // Directed frames under the reset configuration: one coil, function 1.
        push_read_frame(8'd1, 1);
        pdu_beats[$].data = 8'hFF;
        push_beat(8'h81, 1'b0);
        push_beat(8'hAB, 1'b1);
        push_beat(8'h81, 1'b1);
        push_beat(8'h01, 1'b1);
        push_beat(8'hFF, 1'b0);
        push_beat(8'h00, 1'b0);
        push_beat(8'h12, 1'b1);
        push_beat(8'h01, 1'b0);
        push_beat(8'h02, 1'b0);
        push_beat(8'h55, 1'b0);
        push_beat(8'h66, 1'b1);
        push_beat(8'h01, 1'b0);
        push_beat(8'h01, 1'b0);
        push_beat(8'hFF, 1'b0);
        push_beat(8'hAA, 1'b1);
        push_beat(8'h81, 1'b0);
        push_beat(8'h05, 1'b0);
        push_beat(8'hFF, 1'b0);
        push_beat(8'h00, 1'b1);
        push_beat(8'h01, 1'b0);
        push_beat(8'h01, 1'b1);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait_drained();

        set_config(8, 3);
        push_random_phase(150);
        wait_drained();

        set_config(9, 0);
        push_random_phase(150);
        wait_drained();

        // Largest legal field, then a frame long enough to saturate the position.
        set_config(COIL_LIMIT, 127);
        push_read_frame(8'd250, 250);
        push_read_frame(8'd250, 298);
        push_raw_frame(8'hFF, 1);
        push_raw_frame({1'b1, cfg_func}, 1);
        push_read_frame(8'd249, 2);
        wait_drained();

        set_config(0, 1);
        push_random_phase(60);
        wait_drained();

        set_config(2047, 5);
        push_random_phase(60);
        wait_drained();

        set_config($urandom_range(1, 40), $urandom_range(0, 127));
        push_random_phase(200);
        wait_drained();

        set_config($urandom_range(1, 64), $urandom_range(0, 127));
        push_random_phase(250);
        wait_drained();

        set_config(1, 1);
        push_random_phase(100);
        wait_drained();

        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
